### sv/urb_pkg.sv
// Package: shared types and constants of the UART register block.
package urb_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RX    = 2'd2,
        CMD_TX    = 2'd3
    } t_cmd;

    localparam logic [4:0] OFF_DATA = 5'd0;
    localparam logic [4:0] OFF_IER  = 5'd1;
    localparam logic [4:0] OFF_IIR  = 5'd2;
    localparam logic [4:0] OFF_LCR  = 5'd3;
    localparam logic [4:0] OFF_LSR  = 5'd5;
    localparam logic [4:0] OFF_USR  = 5'd31;

    localparam logic [3:0] ID_NONE = 4'd1;
    localparam logic [3:0] ID_THRE = 4'd2;
    localparam logic [3:0] ID_RXD  = 4'd4;
    localparam logic [3:0] ID_LINE = 4'd6;

    // Command from the controller to the datapath for one beat.
    typedef struct packed {
        logic       go;
        t_cmd       cmd;
        logic [4:0] off;
        logic [7:0] wdata;
        logic [7:0] rxd;
        logic       pe;
        logic       fe;
    } t_dp_cmd;

    // Result of the datapath for one beat.
    typedef struct packed {
        logic [7:0] rdata;
        logic [3:0] id;
        logic       txv;
        logic [7:0] txd;
        logic [7:0] lcr;
        logic [15:0] div;
    } t_dp_res;

endpackage

### sv/urb_datapath.sv
// Datapath: registers, queues and read logic of the UART register block.
module urb_datapath #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  urb_pkg::t_dp_cmd  i_cmd,
    output urb_pkg::t_dp_res  o_res
);
    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] TRIG1 = CW'(FIFO_DEPTH / 4);
    localparam logic [CW-1:0] TRIG2 = CW'(FIFO_DEPTH / 2);
    localparam logic [CW-1:0] TRIG3 = CW'(FIFO_DEPTH - 2);

    logic [7:0] r_rxq [FIFO_DEPTH];
    logic [7:0] r_txq [FIFO_DEPTH];

    logic [CW-1:0] r_rx_cnt, n_rx_cnt, r_tx_cnt, n_tx_cnt;
    logic [AW-1:0] r_rx_head, n_rx_head, r_tx_head, n_tx_head;
    logic [2:0] r_ier, n_ier;
    logic [7:0] r_lcr, n_lcr;
    logic       r_fifo, n_fifo;
    logic [1:0] r_trig, n_trig;
    logic [7:0] r_dll, n_dll, r_dlh, n_dlh;
    logic [2:0] r_lerr, n_lerr;
    logic       r_thre, n_thre;
    logic [7:0] r_last, n_last;

    logic [7:0] rdata, txd, mask;
    logic       txv, busy, dlab;
    logic [CW-1:0] cap, trig;
    logic       rx_we, tx_we;
    logic [AW-1:0] rx_wa, tx_wa;
    logic [7:0] rx_wd;
    logic [3:0] id;

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(FIFO_DEPTH)) s = s - (CW+1)'(FIFO_DEPTH);
        return s[AW-1:0];
    endfunction

    function automatic logic [3:0] calc_id(input logic [2:0] ier, input logic [2:0] lerr,
                                           input logic fifo, input logic [CW-1:0] cnt,
                                           input logic [CW-1:0] tl, input logic thre);
        if (ier[2] && lerr != 3'd0) return urb_pkg::ID_LINE;
        if (ier[0] && (fifo ? (cnt >= tl) : (cnt != '0))) return urb_pkg::ID_RXD;
        if (ier[1] && thre) return urb_pkg::ID_THRE;
        return urb_pkg::ID_NONE;
    endfunction

    always_comb begin
        case (r_trig)
            2'd0:    trig = CW'(1);
            2'd1:    trig = TRIG1;
            2'd2:    trig = TRIG2;
            default: trig = TRIG3;
        endcase
    end

    always_comb begin
        logic [3:0] cid;
        n_rx_cnt = r_rx_cnt; n_tx_cnt = r_tx_cnt;
        n_rx_head = r_rx_head; n_tx_head = r_tx_head;
        n_ier = r_ier; n_lcr = r_lcr; n_fifo = r_fifo; n_trig = r_trig;
        n_dll = r_dll; n_dlh = r_dlh; n_lerr = r_lerr; n_thre = r_thre;
        n_last = r_last;
        rdata = 8'd0; txv = 1'b0; txd = 8'd0;
        rx_we = 1'b0; tx_we = 1'b0;
        rx_wa = wrap(r_rx_head, r_rx_cnt);
        tx_wa = wrap(r_tx_head, r_tx_cnt);
        mask = 8'hFF >> (2'd3 - r_lcr[1:0]);
        rx_wd = i_cmd.rxd & mask;
        busy = (r_rx_cnt != '0) || (r_tx_cnt != '0);
        dlab = r_lcr[7];
        cap = r_fifo ? DEPTH_C : CW'(1);
        cid = calc_id(r_ier, r_lerr, r_fifo, r_rx_cnt, trig, r_thre);
        if (i_cmd.go) begin
            case (i_cmd.cmd)
                urb_pkg::CMD_READ: begin
                    case (i_cmd.off)
                        urb_pkg::OFF_DATA: begin
                            if (dlab) rdata = r_dll;
                            else if (r_rx_cnt == '0) rdata = r_last;
                            else begin
                                rdata = r_rxq[r_rx_head];
                                n_last = r_rxq[r_rx_head];
                                n_rx_head = wrap(r_rx_head, CW'(1));
                                n_rx_cnt = r_rx_cnt - CW'(1);
                            end
                        end
                        urb_pkg::OFF_IER: rdata = dlab ? r_dlh : {5'd0, r_ier};
                        urb_pkg::OFF_IIR: begin
                            if (cid == urb_pkg::ID_THRE) n_thre = 1'b0;
                            rdata = {r_fifo, r_fifo, 2'b00, cid};
                        end
                        urb_pkg::OFF_LCR: rdata = r_lcr;
                        urb_pkg::OFF_LSR: begin
                            rdata = {1'b0, r_tx_cnt == '0, r_tx_cnt == '0, 1'b0,
                                     r_lerr, r_rx_cnt != '0};
                            n_lerr = 3'd0;
                        end
                        urb_pkg::OFF_USR: rdata = {3'd0, r_rx_cnt >= cap, r_rx_cnt != '0,
                                                   r_tx_cnt == '0, r_tx_cnt < cap, busy};
                        default: rdata = 8'd0;
                    endcase
                end
                urb_pkg::CMD_WRITE: begin
                    case (i_cmd.off)
                        urb_pkg::OFF_DATA: begin
                            if (dlab) begin
                                if (!busy) n_dll = i_cmd.wdata;
                            end else if (r_tx_cnt < cap) begin
                                tx_we = 1'b1;
                                n_tx_cnt = r_tx_cnt + CW'(1);
                                n_thre = 1'b0;
                            end
                        end
                        urb_pkg::OFF_IER: begin
                            if (dlab) begin
                                if (!busy) n_dlh = i_cmd.wdata;
                            end else begin
                                n_ier = i_cmd.wdata[2:0];
                                if (!r_ier[1] && i_cmd.wdata[1] && r_tx_cnt == '0)
                                    n_thre = 1'b1;
                            end
                        end
                        urb_pkg::OFF_IIR: begin
                            if ((i_cmd.wdata[0] != r_fifo) || i_cmd.wdata[1]) begin
                                n_rx_cnt = '0; n_rx_head = '0;
                            end
                            if ((i_cmd.wdata[0] != r_fifo) || i_cmd.wdata[2]) begin
                                if (r_tx_cnt != '0) n_thre = 1'b1;
                                n_tx_cnt = '0; n_tx_head = '0;
                            end
                            n_fifo = i_cmd.wdata[0];
                            n_trig = i_cmd.wdata[7:6];
                        end
                        urb_pkg::OFF_LCR: if (!busy) n_lcr = i_cmd.wdata;
                        default: ;
                    endcase
                end
                urb_pkg::CMD_RX: begin
                    if (r_rx_cnt < cap) begin
                        rx_we = 1'b1;
                        n_rx_cnt = r_rx_cnt + CW'(1);
                        n_lerr = r_lerr | {i_cmd.fe, i_cmd.pe, 1'b0};
                    end else begin
                        n_lerr = r_lerr | 3'b001;
                    end
                end
                default: begin
                    if (r_tx_cnt != '0) begin
                        txv = 1'b1;
                        txd = r_txq[r_tx_head] & mask;
                        n_tx_head = wrap(r_tx_head, CW'(1));
                        n_tx_cnt = r_tx_cnt - CW'(1);
                        if (r_tx_cnt == CW'(1)) n_thre = 1'b1;
                    end
                end
            endcase
        end
        id = calc_id(n_ier, n_lerr, n_fifo, n_rx_cnt, trig_n(n_trig), n_thre);
    end

    function automatic logic [CW-1:0] trig_n(input logic [1:0] s);
        case (s)
            2'd0:    return CW'(1);
            2'd1:    return TRIG1;
            2'd2:    return TRIG2;
            default: return TRIG3;
        endcase
    endfunction

    always_ff @(posedge i_clk) begin
        if (rx_we) r_rxq[rx_wa] <= rx_wd;
        if (tx_we) r_txq[tx_wa] <= i_cmd.wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_cnt <= '0; r_tx_cnt <= '0; r_rx_head <= '0; r_tx_head <= '0;
            r_ier <= '0; r_lcr <= '0; r_fifo <= 1'b0; r_trig <= '0;
            r_dll <= '0; r_dlh <= '0; r_lerr <= '0; r_thre <= 1'b0; r_last <= '0;
        end else begin
            r_rx_cnt <= n_rx_cnt; r_tx_cnt <= n_tx_cnt;
            r_rx_head <= n_rx_head; r_tx_head <= n_tx_head;
            r_ier <= n_ier; r_lcr <= n_lcr; r_fifo <= n_fifo; r_trig <= n_trig;
            r_dll <= n_dll; r_dlh <= n_dlh; r_lerr <= n_lerr; r_thre <= n_thre;
            r_last <= n_last;
        end
    end

    // Result of this beat, registered by the controller's output stage.
    assign o_res.rdata = rdata;
    assign o_res.id    = id;
    assign o_res.txv   = txv;
    assign o_res.txd   = txd;
    assign o_res.lcr   = n_lcr;
    assign o_res.div   = {n_dlh, n_dll};
endmodule

### sv/urb_ctrl.sv
// Controller: stream handshake and output register of the UART register block.
module urb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [24:0]       i_in_data,
    output urb_pkg::t_dp_cmd  o_cmd,
    input  urb_pkg::t_dp_res  i_res,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output urb_pkg::t_dp_res  o_out
);
    typedef enum logic {S_EMPTY, S_FULL} t_state;
    t_state r_state;
    logic   go;

    // A new beat enters whenever the output register is empty or drains now.
    assign o_in_ready = (r_state == S_EMPTY) || i_out_ready;
    assign go = i_in_valid && o_in_ready;

    assign o_cmd.go    = go;
    assign o_cmd.cmd   = urb_pkg::t_cmd'(i_in_data[1:0]);
    assign o_cmd.off   = i_in_data[6:2];
    assign o_cmd.wdata = i_in_data[14:7];
    assign o_cmd.rxd   = i_in_data[22:15];
    assign o_cmd.pe    = i_in_data[23];
    assign o_cmd.fe    = i_in_data[24];
    assign o_out_valid = (r_state == S_FULL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            case (r_state)
                S_EMPTY: if (go) r_state <= S_FULL;
                S_FULL:  if (i_out_ready && !go) r_state <= S_EMPTY;
                default: r_state <= S_EMPTY;
            endcase
        end
        if (go) o_out <= i_res;
    end
endmodule

### sv/uart_register_block_top.sv
// Top level of the UART register block.
// Each input beat is a bus read, a bus write, a received character or a transmit
// slot, and it yields exactly one output beat in the next cycle, carrying read data,
// the interrupt state, the transmitted character and the current line format and
// divisor. One beat is taken per clock cycle unless the output stalls: the whole
// register update is combinational in the datapath, and a single output register
// decouples the two sides, so the block keeps accepting while the output is being taken.
// Input tdata, from bit 0: command[1:0], reg_offset[4:0], write_data[7:0],
// rx_data[7:0], rx_parity_error, rx_framing_error, zero fill to 32 bits.
// Output tdata, from bit 0: read_data[7:0], irq, interrupt_id[3:0], tx_valid,
// tx_data[7:0], data_bits[3:0], parity_enable, even_parity, two_stop_bits,
// break_out, baud_divisor[15:0], zero fill to 48 bits.
module uart_register_block_top #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // command, reg_offset, write_data, rx_data, pe, fe
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // read_data, irq, id, tx_valid, tx_data, format, divisor
);
    urb_pkg::t_dp_cmd cmd;
    urb_pkg::t_dp_res res, outr;
    logic unused_in;

    assign unused_in = ^s_axis_tdata[31:25];

    urb_datapath #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_res(res)
    );

    urb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata[24:0]), .o_cmd(cmd), .i_res(res),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .o_out(outr)
    );

    // The derived line-format fields come straight from the registered LCR copy.
    assign m_axis_tdata = {unused_in & 1'b0, 1'b0, outr.div,
                           outr.lcr[6], outr.lcr[2], outr.lcr[4], outr.lcr[3],
                           4'd5 + {2'd0, outr.lcr[1:0]},
                           outr.txd, outr.txv, outr.id,
                           outr.id != urb_pkg::ID_NONE, outr.rdata};
endmodule

### sv/urb_checker.sv
// Port checker of the UART register block, bound to the top level.
module urb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid) else $error("no output beat");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("payload moved");
    a_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[8] == (m_axis_tdata[12:9] != 4'd1))
        else $error("irq mismatch");
    a_txd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[13] |-> m_axis_tdata[21:14] == 8'd0)
        else $error("tx data without valid");
endmodule

bind uart_register_block_top urb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
